// ===== sv/fixed_weight_vector_generator_core_macros.svh =====
// Assertion macros for the fixed-weight vector generator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FIXED_WEIGHT_VECTOR_GENERATOR_CORE_MACROS_SVH
`define FIXED_WEIGHT_VECTOR_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FWVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FWVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fwvg_pkg.sv =====
// Shared constants and types for the fixed-weight vector generator.
// No dependencies.
package fwvg_pkg;

  localparam int CODE_LENGTH  = 3488;
  localparam int ERROR_WEIGHT = 64;
  localparam int FIELD_BITS   = 12;

  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;
  localparam int IDX_W       = 6;
  localparam int RAND_W      = 16;
  localparam int VEC_WORDS   = (CODE_LENGTH + WORD_W - 1) / WORD_W;
  localparam int ROUND_WORDS = 2 * ERROR_WEIGHT;
  localparam int ADDR_W      = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
  localparam int LIM_W       = FIELD_BITS + 1;
  localparam int TAKEN_W     = $clog2(ERROR_WEIGHT + 1);
  localparam int ROUND_W     = $clog2(ROUND_WORDS + 1);

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } ram_req_t;

endpackage

// ===== sv/fixed_weight_vector_generator_core.sv =====
// Fixed-weight error vector generator. Each transaction on the input channel
// carries one 16-bit random word; its low FIELD_BITS bits are a candidate
// position. A round is 2*ERROR_WEIGHT words. The first ERROR_WEIGHT candidates
// below CODE_LENGTH are set in a bitmap held in a single-port-write memory of
// VEC_WORDS x 64 bits, and a repeat flag records any position set twice. At the
// end of a round that took ERROR_WEIGHT distinct positions, the bitmap leaves
// as VEC_WORDS output transactions (word 0 first, last_word on the final one),
// each word cleared as it is read; otherwise the bitmap is cleared silently.
// Each input word is handled as a memory read, then a test-and-set with
// write back; the next word is taken only after the write back. Each
// emitted word is read from memory and held until out_ready takes it; a
// silent clear writes zero to all VEC_WORDS words, as does a clearing pass
// after reset, before in_ready first rises. in_ready is low while an item
// is in flight, while the bitmap is emitted and while it is cleared.
module fixed_weight_vector_generator_core
  import fwvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAND_W-1:0] rand_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] vector_word,
  output logic [IDX_W-1:0]  word_index,
  output logic              last_word
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t state;

  // Sweep pointer for clearing and emission.
  logic [ADDR_W-1:0]  ptr;
  logic [TAKEN_W-1:0] taken_count;
  logic [ROUND_W-1:0] round_count;
  logic               repeat_seen;

  // Candidate held between its read and its write back.
  logic               take_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [BIT_W-1:0]   bit_q;

  ram_req_t           ram_req;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  merged;
  logic               hit;

  logic [FIELD_BITS-1:0] cand;
  logic [LIM_W-1:0]      cand_ext;
  logic [LIM_W-1:0]      cand_word;
  logic                  take_now;
  logic                  accept;
  logic                  ptr_last;
  logic [TAKEN_W-1:0]    taken_next;
  logic                  repeat_next;
  logic [ROUND_W-1:0]    round_next;
  logic                  round_done;
  logic                  round_ok;

  fwvg_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  fwvg_mark u_mark (
    .word_in  (rd_data),
    .bit_sel  (bit_q),
    .word_out (merged),
    .hit      (hit)
  );

  // Candidate decode; bits above FIELD_BITS are dropped.
  assign cand      = rand_word[FIELD_BITS-1:0];
  assign cand_ext  = {1'b0, cand};
  assign cand_word = cand_ext >> BIT_W;
  assign take_now  = (cand_ext < LIM_W'(CODE_LENGTH)) &&
                     (taken_count < TAKEN_W'(ERROR_WEIGHT));

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ptr_last = (ptr == ADDR_W'(VEC_WORDS - 1));

  // Round bookkeeping, folding in the item being written back.
  assign taken_next  = taken_count + TAKEN_W'(take_q);
  assign repeat_next = repeat_seen | (take_q & hit);
  assign round_next  = round_count + ROUND_W'(1);
  assign round_done  = (round_next == ROUND_W'(ROUND_WORDS));
  assign round_ok    = (taken_next == TAKEN_W'(ERROR_WEIGHT)) && !repeat_next;

  // Output word comes straight from the registered memory read; it holds
  // while the transaction waits since no read is issued in S_EMIT_WAIT.
  assign vector_word = rd_data;

  always_comb begin
    ram_req = '0;
    unique case (state)
      S_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ptr;
      end
      S_IDLE: begin
        ram_req.rd_en   = accept && take_now;
        ram_req.rd_addr = cand_word[ADDR_W-1:0];
      end
      S_UPD: begin
        ram_req.wr_en   = take_q;
        ram_req.wr_addr = addr_q;
        ram_req.wr_data = merged;
      end
      S_EMIT_RD: begin
        // Read old contents and clear the entry on the same edge.
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = ptr;
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ptr;
      end
      S_EMIT_WAIT: begin
        ram_req = '0;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      ptr         <= '0;
      taken_count <= '0;
      round_count <= '0;
      repeat_seen <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (ptr_last) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            take_q <= take_now;
            addr_q <= cand_word[ADDR_W-1:0];
            bit_q  <= cand[BIT_W-1:0];
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          if (round_done) begin
            taken_count <= '0;
            round_count <= '0;
            repeat_seen <= 1'b0;
            ptr         <= '0;
            state       <= round_ok ? S_EMIT_RD : S_CLEAR;
          end else begin
            taken_count <= taken_next;
            round_count <= round_next;
            repeat_seen <= repeat_next;
            state       <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          out_valid  <= 1'b1;
          word_index <= IDX_W'(ptr);
          last_word  <= ptr_last;
          state      <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_word) begin
              ptr   <= '0;
              state <= S_IDLE;
            end else begin
              ptr   <= ptr + ADDR_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
          ptr   <= '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/fwvg_ram.sv =====
// Bitmap store: one write port, one registered read port.
// Depends on fwvg_pkg.
module fwvg_ram
  import fwvg_pkg::*;
(
  input  logic              clk,
  input  ram_req_t          req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [VEC_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== sv/fwvg_mark.sv =====
// Bit test-and-set unit shared by every candidate of a round.
// Depends on fwvg_pkg.
module fwvg_mark
  import fwvg_pkg::*;
(
  input  logic [WORD_W-1:0] word_in,
  input  logic [BIT_W-1:0]  bit_sel,
  output logic [WORD_W-1:0] word_out,
  output logic              hit
);

  assign hit      = word_in[bit_sel];
  assign word_out = word_in | (WORD_W'(1) << bit_sel);

endmodule

// ===== sv/fwvg_checker.sv =====
// Port-level checker for the fixed-weight vector generator, with its bind.
// Depends on fwvg_pkg and fixed_weight_vector_generator_core_macros.svh.
`include "fixed_weight_vector_generator_core_macros.svh"

module fwvg_checker
  import fwvg_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] word_index,
  input logic             last_word
);

  // No random word is taken while the vector is being delivered.
  `FWVG_ASSERT_NOW(a_no_input_during_emit, out_valid, !in_ready, "input ready during emit")

  // The flagged word is always the top word of the vector.
  `FWVG_ASSERT_NOW(a_last_is_top, out_valid && last_word, word_index == IDX_W'(VEC_WORDS - 1), "last_word on wrong index")

  // After a non-final word is taken, the next word follows with index plus one.
  `FWVG_ASSERT_NEXT(a_index_steps, out_valid && out_ready && !last_word, ##1 (out_valid && word_index == IDX_W'($past(word_index, 2) + IDX_W'(1))), "word_index did not step")

  // A stalled result transaction holds.
  `FWVG_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(word_index) && $stable(last_word), "output changed under stall")

endmodule

bind fixed_weight_vector_generator_core fwvg_checker u_fwvg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word_index (word_index),
  .last_word  (last_word)
);
